FILE: hdl/rau_pkg.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Widths, operation and status codes, sign-magnitude types and helpers.
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam int WORD_BITS     = 32;
   localparam int FIELD_BITS    = 32;
   localparam int WIDE_BITS     = 2 * WORD_BITS;
   localparam int CNT_BITS      = $clog2(WIDE_BITS);
   localparam int OP_BITS       = 4;
   localparam int STATUS_BITS   = 2;
   localparam int REQ_DATA_BITS = 4 * FIELD_BITS;
   localparam int RSP_DATA_BITS = 2 * FIELD_BITS;

   typedef logic [OP_BITS-1:0]     opcode_type;
   typedef logic [STATUS_BITS-1:0] status_type;

   localparam opcode_type OP_ADD  = 4'd0;
   localparam opcode_type OP_SUB  = 4'd1;
   localparam opcode_type OP_MUL  = 4'd2;
   localparam opcode_type OP_DIV  = 4'd3;
   localparam opcode_type OP_IADD = 4'd4;
   localparam opcode_type OP_ISUB = 4'd5;
   localparam opcode_type OP_IMUL = 4'd6;
   localparam opcode_type OP_IDIV = 4'd7;
   localparam opcode_type OP_NEG  = 4'd8;

   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_DIVZERO  = 2'd1;
   localparam status_type ST_OVERFLOW = 2'd2;

   typedef struct packed {
      logic                 neg;
      logic [WORD_BITS-1:0] mag;
   } sm_type;

   typedef struct packed {
      logic                 neg;
      logic [WIDE_BITS-1:0] mag;
   } wide_type;

   function automatic sm_type to_sm(logic [FIELD_BITS-1:0] f);
      logic [WORD_BITS-1:0] m;
      sm_type r;
      m = f[WORD_BITS-1:0];
      r.neg = m[WORD_BITS-1];
      r.mag = r.neg ? (~m + 1'b1) : m;
      return r;
   endfunction

   function automatic wide_type wide_add(wide_type x, wide_type y);
      wide_type r;
      if (x.neg == y.neg) begin
         r.neg = x.neg;
         r.mag = x.mag + y.mag;
      end else if (x.mag >= y.mag) begin
         r.neg = x.neg;
         r.mag = x.mag - y.mag;
      end else begin
         r.neg = y.neg;
         r.mag = y.mag - x.mag;
      end
      return r;
   endfunction

   function automatic logic fits(wide_type v);
      logic small_mag;
      logic at_limit;
      small_mag = (v.mag[WIDE_BITS-1:WORD_BITS-1] == '0);
      at_limit  = (v.mag == (WIDE_BITS'(1'b1) << (WORD_BITS - 1)));
      return small_mag | (v.neg & at_limit);
   endfunction

   function automatic logic [FIELD_BITS-1:0] sext_field(logic [FIELD_BITS-1:0] f);
      return FIELD_BITS'(signed'(f[WORD_BITS-1:0]));
   endfunction

   function automatic logic [FIELD_BITS-1:0] to_field(wide_type v);
      logic [WORD_BITS-1:0] b;
      b = v.mag[WORD_BITS-1:0];
      if (v.neg) begin
         b = ~b + 1'b1;
      end
      return FIELD_BITS'(signed'(b));
   endfunction

endpackage

FILE: hdl/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Integer and negate words pass from idle through the multiply steps, the add
// and the finish to done; echo and zero-divisor words go straight to done.
// Fraction ops add a binary GCD and two divisions, numerator then denominator.
// One word at a time: the next request is taken the cycle after the result is
// queued. Synchronous active-high reset returns the sequencer to idle, no result held.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rau_pkg::REQ_DATA_BITS-1:0]   req_tdata,  // a_num, a_den, b_num, b_den
   input  logic [rau_pkg::OP_BITS-1:0]         req_tuser,  // opcode
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rau_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,  // res_num, res_den
   output logic [rau_pkg::STATUS_BITS-1:0]     rsp_tuser   // status
);

   localparam int FB = rau_pkg::FIELD_BITS;

   typedef enum logic [7:0] {
      S_IDLE = 8'b00000001,
      S_MUL  = 8'b00000010,
      S_ADD  = 8'b00000100,
      S_GCD  = 8'b00001000,
      S_DIVN = 8'b00010000,
      S_DIVD = 8'b00100000,
      S_FIN  = 8'b01000000,
      S_DONE = 8'b10000000
   } state_type;

   localparam rau_pkg::sm_type ONE  = '{neg: 1'b0, mag: rau_pkg::WORD_BITS'(1)};
   localparam rau_pkg::sm_type ZERO = '{neg: 1'b0, mag: '0};

   state_type                   state_ff;
   rau_pkg::opcode_type         op_ff;
   rau_pkg::sm_type             an_ff, ad_ff, bn_ff, bd_ff;
   logic [1:0]                  step_ff;
   rau_pkg::wide_type           t1_ff, t2_ff, num_ff, den_ff;
   logic [FB-1:0]               res_num_ff, res_den_ff;
   rau_pkg::status_type         res_st_ff;
   logic                        rsp_valid_ff;
   logic [rau_pkg::RSP_DATA_BITS-1:0] rsp_data_ff;
   rau_pkg::status_type         rsp_st_ff;
   logic                        gcd_start_ff, div_start_ff;

   rau_pkg::opcode_type         in_op;
   rau_pkg::sm_type             in_an, in_ad, in_bn, in_bd;
   logic                        in_echo, in_dz;
   rau_pkg::sm_type             mx, my, nbn, nan;
   rau_pkg::wide_type           prod;
   logic [rau_pkg::WIDE_BITS-1:0] gcd_g, div_q, div_n;
   logic                        gcd_done, div_done;

   assign in_op = req_tuser;
   assign in_an = rau_pkg::to_sm(req_tdata[FB-1:0]);
   assign in_ad = rau_pkg::to_sm(req_tdata[2*FB-1:FB]);
   assign in_bn = rau_pkg::to_sm(req_tdata[3*FB-1:2*FB]);
   assign in_bd = rau_pkg::to_sm(req_tdata[4*FB-1:3*FB]);
   assign in_echo = (in_op > rau_pkg::OP_NEG);
   assign in_dz = (in_ad.mag == '0) || ((in_op <= rau_pkg::OP_DIV) && (in_bd.mag == '0))
                  || (((in_op == rau_pkg::OP_DIV) || (in_op == rau_pkg::OP_IDIV))
                      && (in_bn.mag == '0));

   assign nbn = '{neg: ~bn_ff.neg, mag: bn_ff.mag};
   assign nan = '{neg: ~an_ff.neg, mag: an_ff.mag};

   always_comb begin
      mx = ZERO;
      my = ONE;
      case (step_ff)
         2'd0: begin
            case (op_ff)
               rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_DIV: begin
                  mx = an_ff; my = bd_ff;
               end
               rau_pkg::OP_MUL, rau_pkg::OP_IMUL: begin
                  mx = an_ff; my = bn_ff;
               end
               rau_pkg::OP_NEG: begin
                  mx = nan; my = ONE;
               end
               default: begin
                  mx = an_ff; my = ONE;
               end
            endcase
         end
         2'd1: begin
            case (op_ff)
               rau_pkg::OP_ADD: begin
                  mx = bn_ff; my = ad_ff;
               end
               rau_pkg::OP_SUB: begin
                  mx = nbn; my = ad_ff;
               end
               rau_pkg::OP_IADD: begin
                  mx = ad_ff; my = bn_ff;
               end
               rau_pkg::OP_ISUB: begin
                  mx = ad_ff; my = nbn;
               end
               default: begin
                  mx = ZERO; my = ONE;
               end
            endcase
         end
         default: begin
            case (op_ff)
               rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_MUL: begin
                  mx = ad_ff; my = bd_ff;
               end
               rau_pkg::OP_DIV, rau_pkg::OP_IDIV: begin
                  mx = ad_ff; my = bn_ff;
               end
               default: begin
                  mx = ad_ff; my = ONE;
               end
            endcase
         end
      endcase
   end

   rau_mul u_mul (
      .clock (clock),
      .x     (mx),
      .y     (my),
      .prod  (prod)
   );

   rau_gcd u_gcd (
      .clock (clock),
      .reset (reset),
      .start (gcd_start_ff),
      .a     (num_ff.mag),
      .b     (den_ff.mag),
      .g     (gcd_g),
      .done  (gcd_done)
   );

   assign div_n = (state_ff == S_DIVD) ? den_ff.mag : num_ff.mag;

   rau_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_n),
      .divisor  (gcd_g),
      .quotient (div_q),
      .done     (div_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         gcd_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
      end else begin
         gcd_start_ff <= (state_ff == S_ADD) && (op_ff <= rau_pkg::OP_DIV);
         div_start_ff <= ((state_ff == S_GCD) && gcd_done)
                         || ((state_ff == S_DIVN) && div_done);
         rsp_valid_ff <= (rsp_valid_ff && !rsp_tready) || (state_ff == S_DONE);
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  op_ff   <= in_op;
                  an_ff   <= in_an;
                  ad_ff   <= in_ad;
                  bn_ff   <= in_bn;
                  bd_ff   <= in_bd;
                  step_ff <= 2'd0;
                  if (in_echo) begin
                     res_num_ff <= rau_pkg::sext_field(req_tdata[FB-1:0]);
                     res_den_ff <= rau_pkg::sext_field(req_tdata[2*FB-1:FB]);
                     res_st_ff  <= rau_pkg::ST_OK;
                     state_ff   <= S_DONE;
                  end else if (in_dz) begin
                     res_num_ff <= '0;
                     res_den_ff <= '0;
                     res_st_ff  <= rau_pkg::ST_DIVZERO;
                     state_ff   <= S_DONE;
                  end else begin
                     state_ff <= S_MUL;
                  end
               end
            end
            S_MUL: begin
               step_ff <= step_ff + 1'b1;
               case (step_ff)
                  2'd1: t1_ff <= prod;
                  2'd2: t2_ff <= prod;
                  2'd3: begin
                     den_ff   <= prod;
                     state_ff <= S_ADD;
                  end
                  default: begin
                  end
               endcase
            end
            S_ADD: begin
               num_ff <= rau_pkg::wide_add(t1_ff, t2_ff);
               if (op_ff <= rau_pkg::OP_DIV) begin
                  state_ff <= S_GCD;
               end else begin
                  state_ff <= S_FIN;
               end
            end
            S_GCD: begin
               if (gcd_done) begin
                  state_ff <= S_DIVN;
               end
            end
            S_DIVN: begin
               if (div_done) begin
                  num_ff.mag <= div_q;
                  state_ff   <= S_DIVD;
               end
            end
            S_DIVD: begin
               if (div_done) begin
                  den_ff.mag <= div_q;
                  state_ff   <= S_FIN;
               end
            end
            S_FIN: begin
               if (rau_pkg::fits(num_ff) && rau_pkg::fits(den_ff)) begin
                  res_num_ff <= rau_pkg::to_field(num_ff);
                  res_den_ff <= rau_pkg::to_field(den_ff);
                  res_st_ff  <= rau_pkg::ST_OK;
               end else begin
                  res_num_ff <= '0;
                  res_den_ff <= '0;
                  res_st_ff  <= rau_pkg::ST_OVERFLOW;
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_data_ff  <= {res_den_ff, res_num_ff};
                  rsp_st_ff    <= res_st_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_st_ff;

   a_start_excl: assert property (@(posedge clock) disable iff (reset)
      !(gcd_start_ff && div_start_ff))
      else $error("GCD and divider started together");

   a_gcd_done_state: assert property (@(posedge clock) disable iff (reset)
      gcd_done |-> (state_ff == S_GCD))
      else $error("GCD finished outside its step");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff != S_IDLE))
      else $error("sequencer stayed idle after taking a word");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == rau_pkg::ST_DIVZERO || rsp_tuser == rau_pkg::ST_OVERFLOW))
      |-> (rsp_tdata == '0))
      else $error("error result carries nonzero data");

endmodule

FILE: hdl/rau_mul.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit multiplier
// Registered sign-magnitude multiply of two word operands.
// ----------------------------------------------------------------------------
module rau_mul (
   input  logic              clock,
   input  rau_pkg::sm_type   x,
   input  rau_pkg::sm_type   y,
   output rau_pkg::wide_type prod
);

   rau_pkg::wide_type prod_ff;

   always_ff @(posedge clock) begin
      prod_ff.neg <= x.neg ^ y.neg;
      prod_ff.mag <= rau_pkg::WIDE_BITS'(x.mag) * rau_pkg::WIDE_BITS'(y.mag);
   end

   assign prod = prod_ff;

endmodule

FILE: hdl/rau_gcd.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit GCD
// Binary GCD of two wide magnitudes, one shift or subtract per cycle.
// ----------------------------------------------------------------------------
module rau_gcd (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [rau_pkg::WIDE_BITS-1:0]      a,
   input  logic [rau_pkg::WIDE_BITS-1:0]      b,
   output logic [rau_pkg::WIDE_BITS-1:0]      g,
   output logic                               done
);

   typedef enum logic [4:0] {
      G_IDLE = 5'b00001,
      G_TWO  = 5'b00010,
      G_ODDX = 5'b00100,
      G_LOOP = 5'b01000,
      G_SHL  = 5'b10000
   } gcd_state_type;

   gcd_state_type                    state_ff;
   logic [rau_pkg::WIDE_BITS-1:0]    x_ff;
   logic [rau_pkg::WIDE_BITS-1:0]    y_ff;
   logic [rau_pkg::CNT_BITS-1:0]     cnt_ff;
   logic                             done_ff;
   logic                             x_gt;
   logic [rau_pkg::WIDE_BITS-1:0]    diff;

   assign x_gt = (x_ff > y_ff);
   assign diff = x_gt ? (x_ff - y_ff) : (y_ff - x_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= G_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (state_ff == G_SHL) && (cnt_ff == '0);
         case (state_ff)
            G_IDLE: begin
               if (start) begin
                  cnt_ff <= '0;
                  if (a == '0) begin
                     x_ff     <= b;
                     state_ff <= G_SHL;
                  end else if (b == '0) begin
                     x_ff     <= a;
                     state_ff <= G_SHL;
                  end else begin
                     x_ff     <= a;
                     y_ff     <= b;
                     state_ff <= G_TWO;
                  end
               end
            end
            G_TWO: begin
               if ((x_ff[0] | y_ff[0]) == 1'b0) begin
                  x_ff   <= x_ff >> 1;
                  y_ff   <= y_ff >> 1;
                  cnt_ff <= cnt_ff + 1'b1;
               end else begin
                  state_ff <= G_ODDX;
               end
            end
            G_ODDX: begin
               if (x_ff[0] == 1'b0) begin
                  x_ff <= x_ff >> 1;
               end else begin
                  state_ff <= G_LOOP;
               end
            end
            G_LOOP: begin
               if (y_ff == '0) begin
                  state_ff <= G_SHL;
               end else if (y_ff[0] == 1'b0) begin
                  y_ff <= y_ff >> 1;
               end else begin
                  if (x_gt) begin
                     x_ff <= y_ff;
                  end
                  y_ff <= diff;
               end
            end
            G_SHL: begin
               if (cnt_ff == '0) begin
                  state_ff <= G_IDLE;
               end else begin
                  x_ff   <= x_ff << 1;
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            default: begin
               state_ff <= G_IDLE;
            end
         endcase
      end
   end

   assign g    = x_ff;
   assign done = done_ff;

endmodule

FILE: hdl/rau_div.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit divider
// Restoring divider for wide magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rau_pkg::WIDE_BITS-1:0] dividend,
   input  logic [rau_pkg::WIDE_BITS-1:0] divisor,
   output logic [rau_pkg::WIDE_BITS-1:0] quotient,
   output logic                          done
);

   logic [rau_pkg::WIDE_BITS-1:0] rem_ff;
   logic [rau_pkg::WIDE_BITS-1:0] quo_ff;
   logic [rau_pkg::WIDE_BITS-1:0] d_ff;
   logic [rau_pkg::CNT_BITS-1:0]  cnt_ff;
   logic                          busy_ff;
   logic                          done_ff;
   logic [rau_pkg::WIDE_BITS:0]   rem_sh;
   logic [rau_pkg::WIDE_BITS:0]   rem_sub;
   logic                          ge;

   assign rem_sh  = {rem_ff, quo_ff[rau_pkg::WIDE_BITS-1]};
   assign ge      = (rem_sh >= {1'b0, d_ff});
   assign rem_sub = rem_sh - {1'b0, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= !start && busy_ff
                    && (cnt_ff == rau_pkg::CNT_BITS'(rau_pkg::WIDE_BITS - 1));
         if (start) begin
            rem_ff  <= '0;
            quo_ff  <= dividend;
            d_ff    <= divisor;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= ge ? rem_sub[rau_pkg::WIDE_BITS-1:0] : rem_sh[rau_pkg::WIDE_BITS-1:0];
            quo_ff <= {quo_ff[rau_pkg::WIDE_BITS-2:0], ge};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == rau_pkg::CNT_BITS'(rau_pkg::WIDE_BITS - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule
